/* rtl/sha1s_pkg.sv */
// Shared types and constants for the SHA-1 stream hasher.
// Command/status structs between controller and datapath, round constants.
// No dependencies.
package sha1s_pkg;

	localparam int unsigned DIGEST_WORDS = 5;
	localparam int unsigned ROUNDS       = 80;

	localparam logic [2:0]  LAST_WORD_IDX = 3'(DIGEST_WORDS - 1);
	localparam logic [6:0]  LAST_ROUND    = 7'(ROUNDS - 1);
	localparam logic [6:0]  ROUND_P1_END  = 7'd20;
	localparam logic [6:0]  ROUND_P2_END  = 7'd40;
	localparam logic [6:0]  ROUND_P3_END  = 7'd60;

	localparam logic [31:0] K_P1 = 32'h5A827999;
	localparam logic [31:0] K_P2 = 32'h6ED9EBA1;
	localparam logic [31:0] K_P3 = 32'h8F1BBCDC;
	localparam logic [31:0] K_P4 = 32'hCA62C1D6;

	localparam logic [31:0] IV0 = 32'h67452301;
	localparam logic [31:0] IV1 = 32'hEFCDAB89;
	localparam logic [31:0] IV2 = 32'h98BADCFE;
	localparam logic [31:0] IV3 = 32'h10325476;
	localparam logic [31:0] IV4 = 32'hC3D2E1F0;

	localparam logic [7:0]  PAD_MARK = 8'h80;

	localparam logic [5:0]  OFF_LAST    = 6'd63;
	localparam logic [5:0]  OFF_PAD_END = 6'd55;

	typedef enum logic [1:0] {
		SEL_DATA = 2'd0,
		SEL_MARK = 2'd1,
		SEL_ZERO = 2'd2,
		SEL_LEN  = 2'd3
	} byte_sel_t;

	typedef struct packed {
		logic      push;
		byte_sel_t sel;
		logic      start_comp;
		logic      round_step;
		logic      fold;
		logic      out_adv;
		logic      reinit;
	} cmd_t;

	typedef struct packed {
		logic off_last;
		logic off_pad_end;
		logic round_last;
		logic idx_last;
	} sts_t;

endpackage

/* rtl/sha1s_datapath.sv */
// Datapath of the SHA-1 stream hasher: 512-bit block shift line, round unit,
// chaining words, byte and offset counters, digest word select.
// Depends on sha1s_pkg; driven by sha1s_ctrl through cmd_t/sts_t.
module sha1s_datapath
	import sha1s_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [7:0]  data_byte,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	logic [511:0] line_q;
	logic [31:0]  work_q [DIGEST_WORDS];
	logic [31:0]  chain_q [DIGEST_WORDS];
	logic [63:0]  count_q;
	logic [5:0]   offset_q;
	logic [6:0]   round_q;
	logic [2:0]   idx_q;

	logic [7:0]   push_byte;
	logic [63:0]  bit_len;
	logic [5:0]   len_pos;
	logic [31:0]  w0, w2, w8, w13, sched_x, sched_w;
	logic [31:0]  a, b, c, d, e, f, k, t;

	assign bit_len = {count_q[60:0], 3'b000};
	// length bytes go out most significant first at offsets 56..63
	assign len_pos = {~offset_q[2:0], 3'b000};

	always_comb begin
		case (cmd.sel)
			SEL_DATA: push_byte = data_byte;
			SEL_MARK: push_byte = PAD_MARK;
			SEL_ZERO: push_byte = 8'h00;
			SEL_LEN:  push_byte = bit_len[len_pos +: 8];
			default:  push_byte = 8'h00;
		endcase
	end

	// window holds w[r..r+15], word 0 in the top bits
	assign w0      = line_q[511:480];
	assign w2      = line_q[447:416];
	assign w8      = line_q[255:224];
	assign w13     = line_q[95:64];
	assign sched_x = w13 ^ w8 ^ w2 ^ w0;
	assign sched_w = {sched_x[30:0], sched_x[31]};

	assign a = work_q[0];
	assign b = work_q[1];
	assign c = work_q[2];
	assign d = work_q[3];
	assign e = work_q[4];

	always_comb begin
		if (round_q < ROUND_P1_END) begin
			f = (b & (c ^ d)) ^ d;
			k = K_P1;
		end else if (round_q < ROUND_P2_END) begin
			f = b ^ c ^ d;
			k = K_P2;
		end else if (round_q < ROUND_P3_END) begin
			f = ((b | c) & d) | (b & c);
			k = K_P3;
		end else begin
			f = b ^ c ^ d;
			k = K_P4;
		end
	end

	assign t = {a[26:0], a[31:27]} + f + e + k + w0;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			line_q <= {line_q[503:0], push_byte};
		end else if (cmd.round_step) begin
			line_q <= {line_q[479:0], sched_w};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_comp) begin
			for (int i = 0; i < DIGEST_WORDS; i++) begin
				work_q[i] <= chain_q[i];
			end
		end else if (cmd.round_step) begin
			work_q[0] <= t;
			work_q[1] <= a;
			work_q[2] <= {b[1:0], b[31:2]};
			work_q[3] <= c;
			work_q[4] <= d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q[0] <= IV0;
			chain_q[1] <= IV1;
			chain_q[2] <= IV2;
			chain_q[3] <= IV3;
			chain_q[4] <= IV4;
			count_q    <= '0;
			offset_q   <= '0;
			round_q    <= '0;
			idx_q      <= '0;
		end else begin
			if (cmd.fold) begin
				for (int i = 0; i < DIGEST_WORDS; i++) begin
					chain_q[i] <= chain_q[i] + work_q[i];
				end
			end else if (cmd.reinit) begin
				chain_q[0] <= IV0;
				chain_q[1] <= IV1;
				chain_q[2] <= IV2;
				chain_q[3] <= IV3;
				chain_q[4] <= IV4;
			end
			if (cmd.reinit) begin
				count_q <= '0;
			end else if (cmd.push && cmd.sel == SEL_DATA) begin
				count_q <= count_q + 64'd1;
			end
			if (cmd.push) begin
				offset_q <= offset_q + 6'd1;
			end
			if (cmd.round_step) begin
				round_q <= (round_q == LAST_ROUND) ? 7'd0 : round_q + 7'd1;
			end
			if (cmd.reinit) begin
				idx_q <= '0;
			end else if (cmd.out_adv) begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	assign sts.off_last    = (offset_q == OFF_LAST);
	assign sts.off_pad_end = (offset_q == OFF_PAD_END);
	assign sts.round_last  = (round_q == LAST_ROUND);
	assign sts.idx_last    = (idx_q == LAST_WORD_IDX);

	assign digest_word = chain_q[idx_q];
	assign word_index  = idx_q;
	assign last_word   = (idx_q == LAST_WORD_IDX);

endmodule

/* rtl/sha1s_ctrl.sv */
// Controller of the SHA-1 stream hasher: sequences byte intake, padding,
// compression rounds, chaining fold and digest readout.
// Depends on sha1s_pkg; drives sha1s_datapath through cmd_t/sts_t.
module sha1s_ctrl
	import sha1s_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic kind,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_MARK = 7'b0000010,
		S_PADZ = 7'b0000100,
		S_LEN  = 7'b0001000,
		S_COMP = 7'b0010000,
		S_FOLD = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   finish_q, finish_d;
	logic   len_done_q, len_done_d;

	always_comb begin
		state_d    = state_q;
		finish_d   = finish_q;
		len_done_d = len_done_q;
		cmd        = '0;
		cmd.sel    = SEL_DATA;
		in_ready   = 1'b0;
		out_valid  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (!kind) begin
						cmd.push = 1'b1;
						if (sts.off_last) begin
							cmd.start_comp = 1'b1;
							state_d        = S_COMP;
						end
					end else begin
						finish_d = 1'b1;
						state_d  = S_MARK;
					end
				end
			end
			S_MARK, S_PADZ: begin
				cmd.push = 1'b1;
				cmd.sel  = (state_q == S_MARK) ? SEL_MARK : SEL_ZERO;
				if (sts.off_last) begin
					cmd.start_comp = 1'b1;
					state_d        = S_COMP;
				end else if (sts.off_pad_end) begin
					state_d = S_LEN;
				end else begin
					state_d = S_PADZ;
				end
			end
			S_LEN: begin
				cmd.push = 1'b1;
				cmd.sel  = SEL_LEN;
				if (sts.off_last) begin
					cmd.start_comp = 1'b1;
					len_done_d     = 1'b1;
					state_d        = S_COMP;
				end
			end
			S_COMP: begin
				cmd.round_step = 1'b1;
				if (sts.round_last) begin
					state_d = S_FOLD;
				end
			end
			S_FOLD: begin
				cmd.fold = 1'b1;
				if (!finish_q) begin
					state_d = S_IDLE;
				end else if (len_done_q) begin
					state_d = S_OUT;
				end else begin
					// length did not fit: start a fresh padding block
					state_d = S_PADZ;
				end
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.out_adv = 1'b1;
					if (sts.idx_last) begin
						cmd.reinit = 1'b1;
						finish_d   = 1'b0;
						len_done_d = 1'b0;
						state_d    = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			finish_q   <= 1'b0;
			len_done_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			finish_q   <= finish_d;
			len_done_q <= len_done_d;
		end
	end

	a_comp_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMP && !sts.round_last) |=> state_q == S_COMP)
		else $error("compression left before the last round");

	a_fold_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FOLD && len_done_q) |=> state_q == S_OUT)
		else $error("final block fold not followed by digest readout");

	a_len_at_56: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_LEN ##1 state_q == S_LEN) |-> $past(sts.off_pad_end))
		else $error("length field started at wrong block offset");

	a_len_needs_finish: assert property (@(posedge clk) disable iff (!arst_n)
		len_done_q |-> finish_q)
		else $error("length appended outside a finish request");

endmodule

/* rtl/sha1_stream_hasher_top.sv */
// SHA-1 stream hasher: one byte per data request, five digest words per finish.
// Data byte: taken in S_IDLE; a byte that completes a block is followed by 80 rounds and the fold.
// Finish: accepted, then the padding/length bytes up to the block end, one per cycle,
// rounds and fold per block (one or two blocks), then 5 output words, one per accepted cycle.
// Sustained throughput is set by the one-round-per-cycle unit; no byte is taken during compression.
// Reset loads the SHA-1 initial chain and clears counters; no clearing pass.
module sha1_stream_hasher_top
	import sha1s_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	cmd_t cmd;
	sts_t sts;

	sha1s_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	sha1s_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.data_byte   (data_byte),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps
// Testbench for sha1_stream_hasher_top: byte requests in, five-word SHA-1 digests out.
// Holds its own SHA-1 predictor and checks every digest word in order.
// Depends only on the RTL under rtl/ (package sha1s_pkg and the top module).
module tb
	import sha1s_pkg::*;
();

	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	localparam int CYCLE_LIMIT    = 200000;
	localparam int LONG_HOLD      = 500;
	localparam int SETTLE_CYCLES  = 100;
	localparam int RAND_REQS      = 20;
	localparam int RAND_MIN_WORDS = 10;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_exp_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        kind;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	// predictor state
	logic [31:0] hv [5];
	logic [63:0] msg_len;
	logic [7:0]  blk [64];

	digest_exp_t digest_q [$];
	digest_exp_t head_exp;

	int errors;
	int cycles;
	int reqs_sent;
	int words_predicted;
	int burst_left;
	bit tx_steady;
	bit rx_steady;
	int stall_asks;
	int stall_served;

	sha1_stream_hasher_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles at %0t", cycles, $time);
			$display("FAIL");
			$finish;
		end
	end

	function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
		return (v << s) | (v >> (32 - s));
	endfunction

	function automatic void sha1_reinit();
		hv[0] = IV0;
		hv[1] = IV1;
		hv[2] = IV2;
		hv[3] = IV3;
		hv[4] = IV4;
		msg_len = '0;
	endfunction

	function automatic void sha1_compress();
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, e, f, k, m, t;
		for (int i = 0; i < 16; i++)
			w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
		a = hv[0];
		b = hv[1];
		c = hv[2];
		d = hv[3];
		e = hv[4];
		for (int r = 0; r < 80; r++) begin
			if (r < 16) begin
				m = w[r];
			end else begin
				m = rotl(w[(r-3)&15] ^ w[(r-8)&15] ^ w[(r-14)&15] ^ w[r&15], 1);
				w[r&15] = m;
			end
			if (r < 20) begin
				f = (b & (c ^ d)) ^ d;
				k = 32'h5A827999;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = 32'h6ED9EBA1;
			end else if (r < 60) begin
				f = ((b | c) & d) | (b & c);
				k = 32'h8F1BBCDC;
			end else begin
				f = b ^ c ^ d;
				k = 32'hCA62C1D6;
			end
			t = rotl(a, 5) + f + e + k + m;
			e = d;
			d = c;
			c = rotl(b, 30);
			b = a;
			a = t;
		end
		hv[0] += a;
		hv[1] += b;
		hv[2] += c;
		hv[3] += d;
		hv[4] += e;
	endfunction

	// Absorb one accepted request; a finish pads, compresses and queues the digest.
	function automatic void sha1_absorb(input logic k, input logic [7:0] b);
		int off;
		logic [63:0] bits;
		digest_exp_t x;
		off = int'(msg_len[5:0]);
		if (k == KIND_DATA) begin
			blk[off] = b;
			msg_len++;
			if (off == 63)
				sha1_compress();
		end else begin
			bits = msg_len << 3;
			blk[off] = 8'h80;
			off++;
			// no room for the length: close this block with zeros first
			if (off > 56) begin
				while (off < 64) begin
					blk[off] = 8'h00;
					off++;
				end
				sha1_compress();
				off = 0;
			end
			while (off < 56) begin
				blk[off] = 8'h00;
				off++;
			end
			for (int i = 0; i < 8; i++)
				blk[56+i] = bits[63-8*i -: 8];
			sha1_compress();
			for (int i = 0; i < 5; i++) begin
				x.word = hv[i];
				x.idx  = 3'(i);
				x.last = (i == 4);
				digest_q.push_back(x);
				words_predicted++;
			end
			sha1_reinit();
		end
	endfunction

	// Receiver: random ready pattern in runs, or a long hold when asked.
	initial begin
		int run_left;
		bit run_level;
		out_ready = 1'b0;
		run_left = 0;
		run_level = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_asks != stall_served) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
				stall_served++;
			end else if (rx_steady) begin
				out_ready <= 1'b1;
			end else begin
				if (run_left == 0) begin
					run_left = $urandom_range(1, 12);
					run_level = ($urandom_range(0, 9) < 6);
				end
				run_left--;
				out_ready <= run_level;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (digest_q.size() == 0) begin
				$display("%0t unexpected digest word: actual %08h idx %0d last %0b",
					$time, digest_word, word_index, last_word);
				errors++;
			end else begin
				head_exp = digest_q.pop_front();
				if (digest_word !== head_exp.word) begin
					$display("%0t digest_word mismatch: expected %08h actual %08h",
						$time, head_exp.word, digest_word);
					errors++;
				end
				if (word_index !== head_exp.idx) begin
					$display("%0t word_index mismatch: expected %0d actual %0d",
						$time, head_exp.idx, word_index);
					errors++;
				end
				if (last_word !== head_exp.last) begin
					$display("%0t last_word mismatch: expected %0b actual %0b",
						$time, head_exp.last, last_word);
					errors++;
				end
			end
		end
	end

	// Offer one request, with a random gap between bursts; return once accepted.
	task automatic send_req(input logic k, input logic [7:0] b);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 8);
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		if (tx_steady)
			gap = 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		kind      <= k;
		data_byte <= b;
		do
			@(posedge clk);
		while (!in_ready);
		reqs_sent++;
		sha1_absorb(k, b);
	endtask

	task automatic send_message(input int len);
		for (int i = 0; i < len; i++)
			send_req(KIND_DATA, 8'($urandom_range(0, 255)));
		send_req(KIND_FINISH, 8'($urandom_range(0, 255)));
	endtask

	// Drop valid and wait for every predicted digest word.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (digest_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_empty_message();
		send_req(KIND_FINISH, 8'h00);
		send_req(KIND_FINISH, 8'hFF);
		drain();
	endtask

	task automatic test_byte_extremes();
		send_req(KIND_DATA, 8'h00);
		send_req(KIND_DATA, 8'hFF);
		send_req(KIND_DATA, 8'h55);
		send_req(KIND_DATA, 8'hAA);
		send_req(KIND_DATA, 8'h80);
		send_req(KIND_DATA, 8'h01);
		send_req(KIND_FINISH, 8'h5A);
		send_req(KIND_DATA, 8'h61);
		send_req(KIND_DATA, 8'h62);
		send_req(KIND_DATA, 8'h63);
		send_req(KIND_FINISH, 8'hA5);
		drain();
	endtask

	// 55 bytes leaves room for the length; 56 forces an extra block.
	task automatic test_pad_boundary();
		send_message(55);
		send_message(56);
		drain();
	endtask

	// Hold the output for a long stretch while more messages are offered at the input.
	task automatic test_backpressure();
		rx_steady = 1'b0;
		stall_asks++;
		send_message(3);
		send_message(70);
		send_message(0);
		send_message(9);
		drain();
	endtask

	task automatic test_random_messages();
		int reqs_start;
		int words_start;
		int len;
		reqs_start = reqs_sent;
		words_start = words_predicted;
		while ((reqs_sent - reqs_start) < RAND_REQS ||
			(words_predicted - words_start) < RAND_MIN_WORDS) begin
			if ($urandom_range(0, 7) == 0)
				len = $urandom_range(50, 72);
			else
				len = $urandom_range(0, 24);
			tx_steady = ($urandom_range(0, 3) == 0);
			rx_steady = ($urandom_range(0, 3) == 0);
			send_message(len);
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_DATA;
		data_byte = 8'h00;
		errors = 0;
		cycles = 0;
		reqs_sent = 0;
		words_predicted = 0;
		burst_left = 0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		stall_asks = 0;
		stall_served = 0;
		for (int i = 0; i < 64; i++)
			blk[i] = 8'h00;
		sha1_reinit();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_message();
		test_byte_extremes();
		test_pad_boundary();
		test_backpressure();
		test_random_messages();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
